// ===== rtl/teq_pkg.sv =====
package teq_pkg;

    localparam int TEQ_CAPACITY = 16;

    typedef enum logic [2:0] {
        OP_SCHEDULE = 3'd0,
        OP_CANCEL   = 3'd1,
        OP_RUN_DUE  = 3'd2,
        OP_RUN_ALL  = 3'd3,
        OP_CLEAR    = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        KIND_ACK     = 3'd0,
        KIND_CANCEL  = 3'd1,
        KIND_FIRED   = 3'd2,
        KIND_DONE    = 3'd3,
        KIND_CLEARED = 3'd4
    } kind_t;

    typedef struct packed {
        logic [31:0] due;
        logic [31:0] id;
        logic [15:0] tag;
    } entry_t;

    typedef enum logic [1:0] {
        RA_ZERO,
        RA_IDX_P1,
        RA_IDX_M2,
        RA_OCC_M1
    } rd_sel_t;

    typedef enum logic [1:0] {
        WA_IDX,
        WA_IDX_M1,
        WA_IDX_MN
    } wa_sel_t;

    typedef enum logic [2:0] {
        IX_HOLD,
        IX_ZERO,
        IX_OCC,
        IX_INC,
        IX_DEC
    } idx_op_t;

    typedef enum logic [2:0] {
        OC_HOLD,
        OC_INC,
        OC_DEC,
        OC_CLR,
        OC_SUB_N
    } occ_op_t;

    typedef struct packed {
        logic    load_in;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wa_sel_t wr_sel;
        logic    wr_new;
        idx_op_t idx_op;
        logic    n_inc;
        logic    lim_load;
        logic    lim_from_ram;
        occ_op_t occ_op;
        logic    id_inc;
        logic    res_load;
        kind_t   res_kind;
        logic    res_found;
        logic    res_status;
        logic    out_fire;
        logic    out_pend;
    } teq_cmd_t;

    typedef struct packed {
        logic occ_zero;
        logic occ_full;
        logic idx_is1;
        logic idx_last;
        logic due_gt;
        logic id_eq;
        logic due_le;
        logic n_zero;
        logic out_free;
    } teq_stat_t;

endpackage

// ===== rtl/timed_event_queue.sv =====
// Each word is served in full before the next is taken: in_stall is high outside idle.
// Schedule walks the sorted table RAM over the entries it moves, cancel walks the whole
// occupancy, run fires the due entries and shifts the rest down, run-all first reads the
// last entry for its limit; empty tables, clear and table-full replies skip the walk. The
// walk moves one entry per cycle unless a due entry waits for room at the output.
// Reset clears occupancy and the id counter; table contents stay undefined, no clearing pass.
module timed_event_queue #(
    parameter int CAPACITY = teq_pkg::TEQ_CAPACITY
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [31:0] time_ms,
    input  logic [31:0] offset_ms,
    input  logic [15:0] command_tag,
    input  logic [31:0] cancel_ref,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [31:0] event_id,
    output logic [15:0] fired_tag,
    output logic        found,
    output logic        status,
    output logic [4:0]  fired_count,
    output logic        last
);
    import teq_pkg::*;

    teq_cmd_t  cmd;
    teq_stat_t stat;

    teq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .operation(operation),
        .stat     (stat),
        .cmd      (cmd)
    );

    teq_dp #(
        .CAPACITY(CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .time_ms    (time_ms),
        .offset_ms  (offset_ms),
        .command_tag(command_tag),
        .cancel_ref (cancel_ref),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .event_id   (event_id),
        .fired_tag  (fired_tag),
        .found      (found),
        .status     (status),
        .fired_count(fired_count),
        .last       (last)
    );

endmodule

// ===== rtl/teq_ram.sv =====
module teq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/teq_dp.sv =====
module teq_dp #(
    parameter int CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  teq_pkg::teq_cmd_t cmd,
    output teq_pkg::teq_stat_t stat,
    input  logic [31:0]       time_ms,
    input  logic [31:0]       offset_ms,
    input  logic [15:0]       command_tag,
    input  logic [31:0]       cancel_ref,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        kind,
    output logic [31:0]       event_id,
    output logic [15:0]       fired_tag,
    output logic              found,
    output logic              status,
    output logic [4:0]        fired_count,
    output logic              last
);
    import teq_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] occ_reg, occ_next;
    logic [31:0]   next_id_reg;
    logic [IW-1:0] idx_reg;
    logic [CW-1:0] n_reg;
    logic [31:0]   due_reg, limit_reg, ref_reg;
    logic [15:0]   tag_reg;

    kind_t         res_kind_reg;
    logic [31:0]   res_id_reg;
    logic          res_found_reg, res_status_reg;
    logic [4:0]    res_count_reg;

    logic          out_valid_reg;
    kind_t         kind_reg;
    logic [31:0]   id_reg;
    logic [15:0]   ftag_reg;
    logic          found_reg, status_reg, last_reg;
    logic [4:0]    count_reg;

    logic          wr_en, rd_en;
    logic [IW-1:0] wr_addr, rd_addr;
    entry_t        wr_data, rd_data;
    logic          out_free;

    teq_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign wr_en = cmd.wr_en;
    assign rd_en = cmd.rd_en;

    always_comb
    begin
        case (cmd.rd_sel)
            RA_ZERO:   rd_addr = '0;
            RA_IDX_P1: rd_addr = idx_reg + 1'b1;
            RA_IDX_M2: rd_addr = idx_reg - IW'(2);
            RA_OCC_M1: rd_addr = IW'(occ_reg - 1'b1);
            default:   rd_addr = '0;
        endcase
        case (cmd.wr_sel)
            WA_IDX:    wr_addr = idx_reg;
            WA_IDX_M1: wr_addr = idx_reg - 1'b1;
            WA_IDX_MN: wr_addr = idx_reg - n_reg[IW-1:0];
            default:   wr_addr = idx_reg;
        endcase
        if (cmd.wr_new)
        begin
            wr_data = '{due: due_reg, id: next_id_reg, tag: tag_reg};
        end
        else
        begin
            wr_data = rd_data;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        stat.occ_zero = (occ_reg == '0);
        stat.occ_full = ((CW+1)'(occ_reg) >= (CW+1)'(CAPACITY));
        stat.idx_is1  = (idx_reg == IW'(1));
        stat.idx_last = ((CW+1)'(idx_reg) + 1'b1 >= (CW+1)'(occ_reg));
        stat.due_gt   = (rd_data.due > due_reg);
        stat.id_eq    = (rd_data.id == ref_reg);
        stat.due_le   = (rd_data.due <= limit_reg);
        stat.n_zero   = (n_reg == '0);
        stat.out_free = out_free;
    end

    always_comb
    begin
        case (cmd.occ_op)
            OC_INC:   occ_next = occ_reg + 1'b1;
            OC_DEC:   occ_next = occ_reg - 1'b1;
            OC_CLR:   occ_next = '0;
            OC_SUB_N: occ_next = occ_reg - n_reg;
            default:  occ_next = occ_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            next_id_reg   <= '0;
            idx_reg       <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (cmd.id_inc)
            begin
                next_id_reg <= next_id_reg + 1'b1;
            end
            case (cmd.idx_op)
                IX_ZERO: idx_reg <= '0;
                IX_OCC:  idx_reg <= occ_reg[IW-1:0];
                IX_INC:  idx_reg <= idx_reg + 1'b1;
                IX_DEC:  idx_reg <= idx_reg - 1'b1;
                default: idx_reg <= idx_reg;
            endcase
            if (cmd.load_in)
            begin
                n_reg <= '0;
            end
            else if (cmd.n_inc)
            begin
                n_reg <= n_reg + 1'b1;
            end
            if (cmd.out_fire || cmd.out_pend)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            due_reg <= time_ms + offset_ms;
            tag_reg <= command_tag;
            ref_reg <= cancel_ref;
        end
        if (cmd.lim_load)
        begin
            limit_reg <= cmd.lim_from_ram ? rd_data.due : time_ms;
        end
        if (cmd.res_load)
        begin
            res_kind_reg   <= cmd.res_kind;
            res_found_reg  <= cmd.res_found;
            res_status_reg <= cmd.res_status;
            res_id_reg     <= (cmd.res_kind == KIND_ACK && !cmd.res_status) ? next_id_reg : '0;
            res_count_reg  <= (cmd.res_kind == KIND_DONE) ? 5'(n_reg) : 5'd0;
        end
        if (cmd.out_fire)
        begin
            kind_reg   <= KIND_FIRED;
            id_reg     <= rd_data.id;
            ftag_reg   <= rd_data.tag;
            found_reg  <= 1'b0;
            status_reg <= 1'b0;
            count_reg  <= 5'd0;
            last_reg   <= 1'b0;
        end
        else if (cmd.out_pend)
        begin
            kind_reg   <= res_kind_reg;
            id_reg     <= res_id_reg;
            ftag_reg   <= 16'd0;
            found_reg  <= res_found_reg;
            status_reg <= res_status_reg;
            count_reg  <= res_count_reg;
            last_reg   <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign event_id    = id_reg;
    assign fired_tag   = ftag_reg;
    assign found       = found_reg;
    assign status      = status_reg;
    assign fired_count = count_reg;
    assign last        = last_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (CW+1)'(occ_reg) <= (CW+1)'(CAPACITY))
        else $error("occupancy beyond capacity");

    a_id_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.id_inc |=> next_id_reg == $past(next_id_reg) + 32'd1)
        else $error("id counter did not advance");

    a_no_load_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_fire || cmd.out_pend) |-> out_free)
        else $error("result loaded over a waiting word");

    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (CW+1)'(wr_addr) < (CW+1)'(CAPACITY))
        else $error("table write out of range");

endmodule

// ===== rtl/teq_ctrl.sv =====
module teq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         operation,
    input  teq_pkg::teq_stat_t stat,
    output teq_pkg::teq_cmd_t  cmd
);
    import teq_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_INS     = 10'b0000000010,
        S_INS_PUT = 10'b0000000100,
        S_CSRCH   = 10'b0000001000,
        S_CSHIFT  = 10'b0000010000,
        S_RLIM    = 10'b0000100000,
        S_RSCAN   = 10'b0001000000,
        S_RSHIFT  = 10'b0010000000,
        S_RDONE   = 10'b0100000000,
        S_FIN     = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg) inside
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    unique case (operation) inside
                        OP_SCHEDULE:
                        begin
                            if (stat.occ_full)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_kind   = KIND_ACK;
                                cmd.res_status = 1'b1;
                                state_next     = S_FIN;
                            end
                            else
                            begin
                                cmd.idx_op = IX_OCC;
                                if (stat.occ_zero)
                                begin
                                    state_next = S_INS_PUT;
                                end
                                else
                                begin
                                    cmd.rd_en  = 1'b1;
                                    cmd.rd_sel = RA_OCC_M1;
                                    state_next = S_INS;
                                end
                            end
                        end
                        OP_CANCEL:
                        begin
                            if (stat.occ_zero)
                            begin
                                cmd.res_load = 1'b1;
                                cmd.res_kind = KIND_CANCEL;
                                state_next   = S_FIN;
                            end
                            else
                            begin
                                cmd.idx_op = IX_ZERO;
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = RA_ZERO;
                                state_next = S_CSRCH;
                            end
                        end
                        OP_RUN_DUE, OP_RUN_ALL:
                        begin
                            cmd.idx_op   = IX_ZERO;
                            cmd.lim_load = 1'b1;
                            cmd.rd_en    = 1'b1;
                            if (stat.occ_zero)
                            begin
                                state_next = S_RDONE;
                            end
                            else if (operation == OP_RUN_ALL)
                            begin
                                cmd.rd_sel = RA_OCC_M1;
                                state_next = S_RLIM;
                            end
                            else
                            begin
                                cmd.rd_sel = RA_ZERO;
                                state_next = S_RSCAN;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cmd.occ_op   = OC_CLR;
                            cmd.res_load = 1'b1;
                            cmd.res_kind = KIND_CLEARED;
                            state_next   = S_FIN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_INS:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WA_IDX;
                if (stat.due_gt)
                begin
                    cmd.idx_op = IX_DEC;
                    if (stat.idx_is1)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RA_IDX_M2;
                    end
                end
                else
                begin
                    cmd.wr_new   = 1'b1;
                    cmd.id_inc   = 1'b1;
                    cmd.occ_op   = OC_INC;
                    cmd.res_load = 1'b1;
                    cmd.res_kind = KIND_ACK;
                    state_next   = S_FIN;
                end
            end
            S_INS_PUT:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = WA_IDX;
                cmd.wr_new   = 1'b1;
                cmd.id_inc   = 1'b1;
                cmd.occ_op   = OC_INC;
                cmd.res_load = 1'b1;
                cmd.res_kind = KIND_ACK;
                state_next   = S_FIN;
            end
            S_CSRCH, S_CSHIFT:
            begin
                if (state_reg == S_CSHIFT)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WA_IDX_M1;
                end
                if (stat.idx_last)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = KIND_CANCEL;
                    if (state_reg == S_CSHIFT || stat.id_eq)
                    begin
                        cmd.res_found = 1'b1;
                        cmd.occ_op    = OC_DEC;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_IDX_P1;
                    cmd.idx_op = IX_INC;
                    if (stat.id_eq)
                    begin
                        state_next = S_CSHIFT;
                    end
                end
            end
            S_RLIM:
            begin
                cmd.lim_load     = 1'b1;
                cmd.lim_from_ram = 1'b1;
                cmd.rd_en        = 1'b1;
                cmd.rd_sel       = RA_ZERO;
                state_next       = S_RSCAN;
            end
            S_RSCAN:
            begin
                if (stat.due_le)
                begin
                    // hold the entry until the output side has room
                    if (stat.out_free)
                    begin
                        cmd.out_fire = 1'b1;
                        cmd.n_inc    = 1'b1;
                        if (stat.idx_last)
                        begin
                            state_next = S_RDONE;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RA_IDX_P1;
                            cmd.idx_op = IX_INC;
                        end
                    end
                end
                else if (stat.n_zero)
                begin
                    state_next = S_RDONE;
                end
                else
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WA_IDX_MN;
                    if (stat.idx_last)
                    begin
                        state_next = S_RDONE;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RA_IDX_P1;
                        cmd.idx_op = IX_INC;
                        state_next = S_RSHIFT;
                    end
                end
            end
            S_RSHIFT:
            begin
                // close the gap left by the fired entries
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = WA_IDX_MN;
                if (stat.idx_last)
                begin
                    state_next = S_RDONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RA_IDX_P1;
                    cmd.idx_op = IX_INC;
                end
            end
            S_RDONE:
            begin
                cmd.occ_op   = OC_SUB_N;
                cmd.res_load = 1'b1;
                cmd.res_kind = KIND_DONE;
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.out_pend = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== verif/tb_timed_event_queue.sv =====
module tb_timed_event_queue;
    timeunit 1ns;
    timeprecision 1ps;
    import teq_pkg::*;

    localparam int CAP = TEQ_CAPACITY;
    localparam int STALL_LIMIT = 5000;
    localparam op_t OP_BAD = op_t'(3'd6);

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] event_id;
        logic [15:0] fired_tag;
        logic        found;
        logic        status;
        logic [4:0]  fired_count;
        logic        last;
    } reply_t;

    typedef struct {
        logic [31:0] due;
        logic [31:0] id;
        logic [15:0] tag;
    } pending_t;

    class queue_scoreboard;
        pending_t    table_q[$];
        logic [31:0] next_id;
        reply_t      replies_due[$];
        int          errors;
        int          checked;

        function void clear_state();
            table_q.delete();
            next_id = '0;
            replies_due.delete();
            errors = 0;
            checked = 0;
        endfunction

        function void push_reply(logic [2:0] k, logic [31:0] id, logic [15:0] tag,
                                 logic f, logic s, logic [4:0] cnt, logic l);
            reply_t r;
            r.kind = k; r.event_id = id; r.fired_tag = tag; r.found = f;
            r.status = s; r.fired_count = cnt; r.last = l;
            replies_due.push_back(r);
        endfunction

        function void fire_up_to(logic [31:0] limit);
            int n;
            n = 0;
            while (table_q.size() > 0 && table_q[0].due <= limit)
            begin
                push_reply(KIND_FIRED, table_q[0].id, table_q[0].tag, 0, 0, 0, 0);
                void'(table_q.pop_front());
                n++;
            end
            push_reply(KIND_DONE, 0, 0, 0, 0, n[4:0], 1);
        endfunction

        // work out every reply that one accepted word causes
        function void note_word(logic [2:0] op, logic [31:0] now, logic [31:0] ofs,
                                logic [15:0] tag, logic [31:0] ref_id);
            pending_t e;
            int pos;
            int hit;
            case (op)
                OP_SCHEDULE:
                begin
                    if (table_q.size() >= CAP)
                        push_reply(KIND_ACK, 0, 0, 0, 1, 0, 1);
                    else
                    begin
                        e.due = now + ofs; e.id = next_id; e.tag = tag;
                        pos = 0;
                        while (pos < table_q.size() && table_q[pos].due <= e.due)
                            pos++;
                        table_q.insert(pos, e);
                        push_reply(KIND_ACK, next_id, 0, 0, 0, 0, 1);
                        next_id = next_id + 1;
                    end
                end
                OP_CANCEL:
                begin
                    hit = -1;
                    foreach (table_q[i])
                        if (hit < 0 && table_q[i].id == ref_id)
                            hit = i;
                    if (hit >= 0)
                        table_q.delete(hit);
                    push_reply(KIND_CANCEL, 0, 0, hit >= 0, 0, 0, 1);
                end
                OP_RUN_DUE:
                    fire_up_to(now);
                OP_RUN_ALL:
                    if (table_q.size() == 0)
                        push_reply(KIND_DONE, 0, 0, 0, 0, 0, 1);
                    else
                        fire_up_to(table_q[$].due);
                OP_CLEAR:
                begin
                    table_q.delete();
                    push_reply(KIND_CLEARED, 0, 0, 0, 0, 0, 1);
                end
                default: ;
            endcase
        endfunction

        function void check_reply(reply_t got);
            reply_t w;
            checked++;
            if (replies_due.size() == 0)
            begin
                $error("unexpected reply kind %0d", got.kind);
                errors++;
                return;
            end
            w = replies_due.pop_front();
            if (got.kind !== w.kind)
            begin $error("kind exp %0d got %0d", w.kind, got.kind); errors++; end
            if (got.event_id !== w.event_id)
            begin $error("event_id exp %0d got %0d", w.event_id, got.event_id); errors++; end
            if (got.fired_tag !== w.fired_tag)
            begin $error("fired_tag exp %0h got %0h", w.fired_tag, got.fired_tag); errors++; end
            if (got.found !== w.found)
            begin $error("found exp %0d got %0d", w.found, got.found); errors++; end
            if (got.status !== w.status)
            begin $error("status exp %0d got %0d", w.status, got.status); errors++; end
            if (got.fired_count !== w.fired_count)
            begin
                $error("fired_count exp %0d got %0d", w.fired_count, got.fired_count);
                errors++;
            end
            if (got.last !== w.last)
            begin $error("last exp %0d got %0d", w.last, got.last); errors++; end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [2:0]  operation = '0;
    logic [31:0] time_ms = '0;
    logic [31:0] offset_ms = '0;
    logic [15:0] command_tag = '0;
    logic [31:0] cancel_ref = '0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [2:0]  kind;
    logic [31:0] event_id;
    logic [15:0] fired_tag;
    logic        found;
    logic        status;
    logic [4:0]  fired_count;
    logic        last;

    queue_scoreboard sb = new();
    bit   quiet_tail = 0;
    int   idle_cycles = 0;
    int   words_sent = 0;
    logic [31:0] clock_ms = 0;

    always #5 clk = ~clk;

    timed_event_queue dut (.*);

    // output side: random stall bursts, check each accepted reply
    always @(posedge clk)
    begin
        reply_t r;
        if (rst_n && out_valid && !out_stall)
        begin
            r.kind = kind; r.event_id = event_id; r.fired_tag = fired_tag;
            r.found = found; r.status = status; r.fired_count = fired_count;
            r.last = last;
            sb.check_reply(r);
        end
    end

    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 16);
                out_stall <= 1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 0;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL timed_event_queue");
            $finish;
        end
    end

    // valid stays high from one word to the next; drop it only for a gap
    task automatic send_word(op_t op, logic [31:0] now, logic [31:0] ofs,
                             logic [15:0] tag, logic [31:0] ref_id);
        int gap;
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1;
        operation <= op; time_ms <= now; offset_ms <= ofs;
        command_tag <= tag; cancel_ref <= ref_id;
        do @(posedge clk); while (in_stall);
        sb.note_word(op, now, ofs, tag, ref_id);
        words_sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.replies_due.size() > 0)
            @(posedge clk);
        repeat (CAP + 8) @(posedge clk);
    endtask

    task automatic random_word();
        int pick;
        logic [31:0] ref_id;
        pick = $urandom_range(0, 99);
        clock_ms = clock_ms + $urandom_range(0, 40);
        if (pick < 45)
            send_word(OP_SCHEDULE, clock_ms,
                      ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 120),
                      $urandom, 0);
        else if (pick < 62)
        begin
            ref_id = ($urandom_range(0, 3) == 0) ? $urandom
                     : sb.next_id - $urandom_range(1, 20);
            send_word(OP_CANCEL, $urandom, $urandom, $urandom, ref_id);
        end
        else if (pick < 82)
            send_word(OP_RUN_DUE, clock_ms + $urandom_range(0, 80), $urandom, $urandom, 0);
        else if (pick < 90)
            send_word(OP_RUN_ALL, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 95)
            send_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
        else
            send_word(op_t'(3'($urandom_range(5, 7))), $urandom, $urandom, $urandom, 0);
    endtask

    initial
    begin
        sb.clear_state();
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty runs, ties, wrap, fill past capacity, cancels, clear
        send_word(OP_RUN_DUE, 32'hFFFF_FFFF, 0, 0, 0);
        send_word(OP_RUN_ALL, 0, 0, 0, 0);
        send_word(OP_CANCEL, 0, 0, 0, 32'hFFFF_FFFF);
        send_word(OP_SCHEDULE, 32'hFFFF_FFF0, 32'h20, 16'hFFFF, 0);
        send_word(OP_SCHEDULE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 0);
        send_word(OP_SCHEDULE, 10, 20, 16'hA5A5, 0);
        send_word(OP_SCHEDULE, 30, 0, 16'h5A5A, 0);
        send_word(OP_BAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(OP_CANCEL, 0, 0, 0, 1);
        send_word(OP_CANCEL, 0, 0, 0, 1);
        send_word(OP_RUN_DUE, 30, 0, 0, 0);
        send_word(OP_RUN_ALL, 0, 0, 0, 0);
        for (int i = 0; i < CAP + 1; i++)
            send_word(OP_SCHEDULE, 100, i % 3, 16'(i), 0);
        send_word(OP_RUN_DUE, 100, 0, 0, 0);
        send_word(OP_CLEAR, 0, 0, 0, 0);
        // hold off until the block has answered everything
        drain();

        for (int i = 0; i < 80; i++)
        begin
            if (i == 62)
                quiet_tail = 1;
            random_word();
        end
        drain();

        $display("Ran %0d words, %0d replies checked, through empty, full and wrapped tables.",
                 words_sent, sb.checked);
        if (sb.errors == 0 && sb.replies_due.size() == 0)
            $display("PASS timed_event_queue");
        else
            $display("FAIL timed_event_queue");
        $finish;
    end
endmodule
